FILE: hw/rtl/elevator_collective_controller_defines.svh
// Assertion macros shared by the elevator controller RTL.
`ifndef ELEVATOR_COLLECTIVE_CONTROLLER_DEFINES_SVH
`define ELEVATOR_COLLECTIVE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ECC_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("elevator controller check failed");

// Next-cycle implication, checked out of reset.
`define ECC_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("elevator controller check failed");

`endif

FILE: hw/rtl/ecc_pkg.sv
// Shared types, codes and sizes of the elevator controller.
package ecc_pkg;

    localparam int FLOORS      = 4;
    localparam int TABLE_SLOTS = 16;
    localparam int FW          = 2;
    localparam int IW          = $clog2(TABLE_SLOTS);
    localparam int CW          = $clog2(TABLE_SLOTS + 1);
    localparam int POS_W       = 10;
    localparam int TMR_W       = 9;
    localparam int DW          = $clog2(FLOORS + 1);
    localparam int REM_W       = POS_W + 2;

    localparam logic [2:0] CFG_STEPS    = 3'd0;
    localparam logic [2:0] CFG_DOOR     = 3'd1;
    localparam logic [2:0] CFG_IDLE_RET = 3'd2;
    localparam logic [2:0] CFG_CAPACITY = 3'd3;
    localparam logic [2:0] CFG_FULL_THR = 3'd4;

    typedef enum logic [1:0] {CM_IDLE, CM_MOVING, CM_STOPPED} car_mode_t;
    typedef enum logic [1:0] {DIR_LOW, DIR_HIGH, DIR_NONE} dir_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_DIV_INIT, OP_DIV_STEP, OP_REQ, OP_TICK, OP_IDLE_TICK,
        OP_MOVE, OP_SCAN_INIT, OP_ICPT_STEP, OP_DROP_STEP, OP_DROP_END,
        OP_BDIR_STEP, OP_BDIR_END, OP_BOARD_STEP, OP_BOARD_END, OP_MASK_STEP,
        OP_MASK_END, OP_NEAR_INIT, OP_NEAR_STEP, OP_NEAR_END, OP_DSCAN_INIT,
        OP_DSCAN_STEP, OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic      done;
        logic      scan_end;
        logic      is_req;
        logic      waiting_any;
        car_mode_t car_mode;
        logic      door_due;
        logic      icpt_pend;
        logic      masks_empty;
        logic      dir_none;
    } dp_status_t;

endpackage

FILE: hw/rtl/ecc_ctrl.sv
// Sequencer that steps the datapath through one item at a time.
module ecc_ctrl
    import ecc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_WAIT, S_DIV_INIT, S_DIV, S_REQ, S_TICK, S_DISPATCH, S_IDLE_TICK, S_MOVE,
        S_ICPT_INIT, S_ICPT, S_DROP_INIT, S_DROP, S_DROP_END, S_BDIR_INIT, S_BDIR,
        S_BDIR_END, S_BOARD_INIT, S_BOARD, S_BOARD_END, S_MASK_INIT, S_MASK,
        S_MASK_END, S_NEAR_INIT, S_NEAR, S_NEAR_END, S_DSCAN_INIT, S_DSCAN, S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   post_reg, post_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        post_next    = post_reg;
        m_valid_next = m_valid_reg;
        cmd.op       = OP_NOP;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_WAIT: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    post_next  = 1'b0;
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op = OP_DIV_STEP;
                if (status.done) begin
                    if (post_reg) begin
                        state_next = status.icpt_pend ? S_ICPT_INIT : S_EMIT;
                    end else begin
                        state_next = status.is_req ? S_REQ : S_TICK;
                    end
                end
            end
            S_REQ: begin
                cmd.op     = OP_REQ;
                state_next = S_EMIT;
            end
            S_TICK: begin
                cmd.op     = OP_TICK;
                state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (status.car_mode)
                    CM_IDLE:    state_next = S_IDLE_TICK;
                    CM_MOVING:  state_next = S_MOVE;
                    CM_STOPPED: state_next = status.door_due ? S_DROP_INIT : S_EMIT;
                    default:    state_next = S_EMIT;
                endcase
            end
            S_IDLE_TICK: begin
                cmd.op     = OP_IDLE_TICK;
                state_next = status.waiting_any ? S_MASK_INIT : S_EMIT;
            end
            S_MOVE: begin
                cmd.op     = OP_MOVE;
                post_next  = 1'b1;
                state_next = S_DIV_INIT;
            end
            S_ICPT_INIT: begin
                cmd.op     = OP_SCAN_INIT;
                state_next = S_ICPT;
            end
            S_ICPT: begin
                cmd.op = OP_ICPT_STEP;
                if (status.scan_end || status.done) begin
                    state_next = S_EMIT;
                end
            end
            S_DROP_INIT: begin
                cmd.op     = OP_SCAN_INIT;
                state_next = S_DROP;
            end
            S_DROP: begin
                cmd.op = OP_DROP_STEP;
                if (status.scan_end) begin
                    state_next = S_DROP_END;
                end
            end
            S_DROP_END: begin
                cmd.op     = OP_DROP_END;
                state_next = S_BDIR_INIT;
            end
            S_BDIR_INIT: begin
                cmd.op     = OP_SCAN_INIT;
                state_next = S_BDIR;
            end
            S_BDIR: begin
                cmd.op = OP_BDIR_STEP;
                if (status.scan_end) begin
                    state_next = S_BDIR_END;
                end
            end
            S_BDIR_END: begin
                cmd.op     = OP_BDIR_END;
                state_next = S_BOARD_INIT;
            end
            S_BOARD_INIT: begin
                cmd.op     = OP_SCAN_INIT;
                state_next = S_BOARD;
            end
            S_BOARD: begin
                cmd.op = OP_BOARD_STEP;
                if (status.scan_end) begin
                    state_next = S_BOARD_END;
                end
            end
            S_BOARD_END: begin
                cmd.op     = OP_BOARD_END;
                state_next = S_MASK_INIT;
            end
            S_MASK_INIT: begin
                cmd.op     = OP_SCAN_INIT;
                state_next = S_MASK;
            end
            S_MASK: begin
                cmd.op = OP_MASK_STEP;
                if (status.scan_end) begin
                    state_next = S_MASK_END;
                end
            end
            S_MASK_END: begin
                cmd.op = OP_MASK_END;
                if (status.masks_empty) begin
                    state_next = S_EMIT;
                end else if (status.dir_none) begin
                    state_next = S_NEAR_INIT;
                end else begin
                    state_next = S_DSCAN_INIT;
                end
            end
            S_NEAR_INIT: begin
                cmd.op     = OP_NEAR_INIT;
                state_next = S_NEAR;
            end
            S_NEAR: begin
                cmd.op = OP_NEAR_STEP;
                if (status.done) begin
                    state_next = S_NEAR_END;
                end
            end
            S_NEAR_END: begin
                cmd.op     = OP_NEAR_END;
                state_next = S_EMIT;
            end
            S_DSCAN_INIT: begin
                cmd.op     = OP_DSCAN_INIT;
                state_next = S_DSCAN;
            end
            S_DSCAN: begin
                cmd.op = OP_DSCAN_STEP;
                if (status.done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_EMIT;
                    m_valid_next = 1'b1;
                    state_next   = S_WAIT;
                end
            end
            default: state_next = S_WAIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_WAIT;
            post_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            post_reg    <= post_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_WAIT);
    assign m_valid = m_valid_reg;

endmodule

FILE: hw/rtl/ecc_dp.sv
// Datapath: rider table, car state, floor divider, scan units and result register.
module ecc_dp
    import ecc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    input  logic             s_mode,
    input  logic [1:0]       s_start_floor,
    input  logic [1:0]       s_dest_floor,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_addr,
    input  logic [8:0]       cfg_data,
    output logic [1:0]       m_car_floor,
    output logic [POS_W-1:0] m_car_position,
    output logic [1:0]       m_car_mode,
    output logic [1:0]       m_travel_direction,
    output logic             m_goal_valid,
    output logic [1:0]       m_goal_floor,
    output logic [4:0]       m_riders_inside,
    output logic [4:0]       m_riders_waiting,
    output logic             m_request_rejected
);

    localparam logic [FW-1:0] HOME = FW'(FLOORS - 1);

    // configuration
    logic [7:0] spf_reg;
    logic [8:0] door_reg, idle_reg;
    logic [4:0] cap_reg, thr_reg;

    // rider table
    logic [FW-1:0] start_mem [TABLE_SLOTS];
    logic [FW-1:0] dest_mem  [TABLE_SLOTS];
    logic          in_mem    [TABLE_SLOTS];
    logic          tbl_we, tbl_win;
    logic [IW-1:0] tbl_waddr;
    logic [FW-1:0] tbl_wstart, tbl_wdest;

    logic [CW-1:0]    cnt_reg, cnt_next, ins_reg, ins_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    car_mode_t        mode_reg, mode_next;
    dir_t             dir_reg, dir_next, bdir_reg, bdir_next;
    logic             gv_reg, gv_next;
    logic [FW-1:0]    goal_reg, goal_next;
    logic [TMR_W-1:0] tmr_reg, tmr_next;

    logic             in_mode_reg, in_mode_next;
    logic [FW-1:0]    in_s_reg, in_s_next, in_d_reg, in_d_next;
    logic             rej_reg, rej_next, icpt_reg, icpt_next;

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [FW-1:0]    q_reg, q_next, cf_reg, cf_next;
    logic             done_reg, done_next;

    logic [CW-1:0]    idx_reg, idx_next, j_reg, j_next;
    logic             wl_reg, wl_next, wh_reg, wh_next;
    logic [FLOORS-1:0] dests_reg, dests_next, lows_reg, lows_next, highs_reg, highs_next;

    logic [1:0]    nk_reg, nk_next;
    logic [FW-1:0] nf_reg, nf_next, best_reg, best_next, sf_reg, sf_next;
    logic [DW-1:0] mind_reg, mind_next;
    logic          found_reg, found_next, pass_reg, pass_next;

    logic [1:0]       o_cf_reg, o_mode_reg, o_dir_reg, o_gf_reg;
    logic [POS_W-1:0] o_pos_reg;
    logic             o_gv_reg, o_rej_reg;
    logic [4:0]       o_ins_reg, o_wait_reg;

    logic [7:0]        spf_eff;
    logic [REM_W-1:0]  twos;
    logic [POS_W-1:0]  target;
    logic [FW-1:0]     e_start, e_dest;
    logic              e_in, scan_end, full;
    logic [FLOORS-1:0] near_set, want;
    logic [FW-1:0]     ndist;
    logic              way;

    assign spf_eff  = (spf_reg == 8'd0) ? 8'd1 : spf_reg;
    assign twos     = REM_W'({spf_eff, 1'b0});
    assign target   = POS_W'(goal_reg) * POS_W'(spf_eff);
    assign e_start  = start_mem[idx_reg[IW-1:0]];
    assign e_dest   = dest_mem[idx_reg[IW-1:0]];
    assign e_in     = in_mem[idx_reg[IW-1:0]];
    assign scan_end = (idx_reg == cnt_reg);
    assign full     = (ins_reg >= thr_reg);
    assign near_set = (nk_reg == 2'd0) ? dests_reg : ((nk_reg == 2'd1) ? lows_reg : highs_reg);
    assign ndist    = (nf_reg > cf_reg) ? (nf_reg - cf_reg) : (cf_reg - nf_reg);
    assign want     = dests_reg | (full ? '0 : ((dir_reg == DIR_LOW) ? lows_reg : highs_reg));
    assign way      = (bdir_reg == DIR_LOW) ? (e_dest < cf_reg) : (e_dest > cf_reg);

    always_comb begin
        cnt_next = cnt_reg;       ins_next = ins_reg;     pos_next = pos_reg;
        mode_next = mode_reg;     dir_next = dir_reg;     bdir_next = bdir_reg;
        gv_next = gv_reg;         goal_next = goal_reg;   tmr_next = tmr_reg;
        in_mode_next = in_mode_reg; in_s_next = in_s_reg; in_d_next = in_d_reg;
        rej_next = rej_reg;       icpt_next = icpt_reg;
        rem_next = rem_reg;       q_next = q_reg;         cf_next = cf_reg;
        done_next = done_reg;     idx_next = idx_reg;     j_next = j_reg;
        wl_next = wl_reg;         wh_next = wh_reg;
        dests_next = dests_reg;   lows_next = lows_reg;   highs_next = highs_reg;
        nk_next = nk_reg;         nf_next = nf_reg;       best_next = best_reg;
        mind_next = mind_reg;     found_next = found_reg;
        sf_next = sf_reg;         pass_next = pass_reg;
        tbl_we = 1'b0;            tbl_waddr = cnt_reg[IW-1:0];
        tbl_wstart = in_s_reg;    tbl_wdest = in_d_reg;   tbl_win = 1'b0;

        case (cmd.op)
            OP_LOAD: begin
                in_mode_next = s_mode;
                in_s_next    = s_start_floor;
                in_d_next    = s_dest_floor;
                rej_next     = 1'b0;
                icpt_next    = 1'b0;
            end
            OP_DIV_INIT: begin
                rem_next  = REM_W'({pos_reg, 1'b0}) + REM_W'(spf_eff);
                q_next    = '0;
                done_next = 1'b0;
            end
            OP_DIV_STEP: begin
                if (!done_reg) begin
                    if (rem_reg >= twos && q_reg != HOME) begin
                        rem_next = rem_reg - twos;
                        q_next   = q_reg + 1'b1;
                    end else begin
                        done_next = 1'b1;
                        cf_next   = q_reg;
                    end
                end
            end
            OP_REQ: begin
                if (cnt_reg >= CW'(TABLE_SLOTS) || in_s_reg == in_d_reg
                    || 32'(in_s_reg) >= FLOORS || 32'(in_d_reg) >= FLOORS) begin
                    rej_next = 1'b1;
                end else begin
                    tbl_we   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_TICK: begin
                if (tmr_reg != '1) begin
                    tmr_next = tmr_reg + 1'b1;
                end
            end
            OP_IDLE_TICK: begin
                if (!(cnt_reg > ins_reg) && cf_reg != HOME && tmr_reg > idle_reg) begin
                    gv_next   = 1'b1;
                    goal_next = HOME;
                    mode_next = CM_MOVING;
                    dir_next  = DIR_HIGH;
                end
            end
            OP_MOVE: begin
                if (!gv_reg) begin
                    mode_next = CM_IDLE;
                end else if (pos_reg == target) begin
                    mode_next = CM_STOPPED;
                    tmr_next  = '0;
                end else begin
                    pos_next  = (pos_reg > target) ? pos_reg - 1'b1 : pos_reg + 1'b1;
                    icpt_next = (dir_reg == DIR_HIGH) && (goal_reg == HOME);
                end
            end
            OP_SCAN_INIT: begin
                idx_next   = '0;
                j_next     = '0;
                done_next  = 1'b0;
                wl_next    = 1'b0;
                wh_next    = 1'b0;
                dests_next = '0;
                lows_next  = '0;
                highs_next = '0;
            end
            OP_ICPT_STEP: begin
                if (!scan_end && !done_reg) begin
                    if (!e_in && e_start >= cf_reg && e_start < goal_reg) begin
                        goal_next = e_start;
                        done_next = 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            OP_DROP_STEP: begin
                if (!scan_end) begin
                    if (e_in && e_dest == cf_reg) begin
                        ins_next = ins_reg - 1'b1;
                    end else begin
                        // pack the kept entry down to the write slot
                        tbl_we     = 1'b1;
                        tbl_waddr  = j_reg[IW-1:0];
                        tbl_wstart = e_start;
                        tbl_wdest  = e_dest;
                        tbl_win    = e_in;
                        j_next     = j_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            OP_DROP_END: begin
                cnt_next = j_reg;
            end
            OP_BDIR_STEP: begin
                if (!scan_end) begin
                    if (!e_in && e_start == cf_reg) begin
                        if (e_dest < cf_reg) begin
                            wl_next = 1'b1;
                        end else begin
                            wh_next = 1'b1;
                        end
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            OP_BDIR_END: begin
                if (dir_reg != DIR_NONE) begin
                    bdir_next = dir_reg;
                end else if (wl_reg) begin
                    bdir_next = DIR_LOW;
                end else if (wh_reg) begin
                    bdir_next = DIR_HIGH;
                end else begin
                    bdir_next = DIR_NONE;
                end
            end
            OP_BOARD_STEP: begin
                if (!scan_end) begin
                    if (bdir_reg != DIR_NONE && !e_in && e_start == cf_reg && way
                        && ins_reg < cap_reg) begin
                        tbl_we     = 1'b1;
                        tbl_waddr  = idx_reg[IW-1:0];
                        tbl_wstart = e_start;
                        tbl_wdest  = e_dest;
                        tbl_win    = 1'b1;
                        ins_next   = ins_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            OP_BOARD_END: begin
                if (dir_reg == DIR_NONE && bdir_reg != DIR_NONE) begin
                    dir_next = bdir_reg;
                end
            end
            OP_MASK_STEP: begin
                if (!scan_end) begin
                    if (e_in) begin
                        dests_next[e_dest] = 1'b1;
                    end else if (e_dest < e_start) begin
                        lows_next[e_start] = 1'b1;
                    end else begin
                        highs_next[e_start] = 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            OP_MASK_END: begin
                if ((dests_reg | lows_reg | highs_reg) == '0) begin
                    if (mode_reg != CM_IDLE) begin
                        tmr_next = '0;
                    end
                    mode_next = CM_IDLE;
                    dir_next  = DIR_NONE;
                    gv_next   = 1'b0;
                end
            end
            OP_NEAR_INIT: begin
                nk_next    = '0;
                nf_next    = '0;
                mind_next  = DW'(FLOORS);
                best_next  = '0;
                found_next = 1'b0;
                done_next  = 1'b0;
            end
            OP_NEAR_STEP: begin
                if (!done_reg) begin
                    // hall call sets count only while the car is below the full threshold
                    if (!(nk_reg != 2'd0 && full) && near_set[nf_reg]
                        && DW'(ndist) < mind_reg) begin
                        mind_next  = DW'(ndist);
                        best_next  = nf_reg;
                        found_next = 1'b1;
                    end
                    if (nf_reg == HOME) begin
                        nf_next = '0;
                        nk_next = nk_reg + 1'b1;
                        if (nk_reg == 2'd2) begin
                            done_next = 1'b1;
                        end
                    end else begin
                        nf_next = nf_reg + 1'b1;
                    end
                end
            end
            OP_NEAR_END: begin
                if (!found_reg) begin
                    mode_next = CM_IDLE;
                end else begin
                    gv_next   = 1'b1;
                    goal_next = best_reg;
                    if (best_reg == cf_reg) begin
                        mode_next = CM_STOPPED;
                        tmr_next  = '0;
                    end else begin
                        mode_next = CM_MOVING;
                        dir_next  = (best_reg < cf_reg) ? DIR_LOW : DIR_HIGH;
                    end
                end
            end
            OP_DSCAN_INIT: begin
                sf_next   = cf_reg;
                pass_next = 1'b0;
                done_next = 1'b0;
            end
            OP_DSCAN_STEP: begin
                if (!done_reg) begin
                    if (want[sf_reg]) begin
                        gv_next   = 1'b1;
                        goal_next = sf_reg;
                        done_next = 1'b1;
                        if (sf_reg == cf_reg) begin
                            mode_next = CM_STOPPED;
                            tmr_next  = '0;
                        end else begin
                            mode_next = CM_MOVING;
                        end
                    end else if ((dir_reg == DIR_LOW && sf_reg == '0)
                                 || (dir_reg != DIR_LOW && sf_reg == HOME)) begin
                        // reverse once, then give up
                        if (pass_reg) begin
                            mode_next = CM_IDLE;
                            dir_next  = DIR_NONE;
                            done_next = 1'b1;
                        end else begin
                            dir_next  = (dir_reg == DIR_LOW) ? DIR_HIGH : DIR_LOW;
                            pass_next = 1'b1;
                            sf_next   = cf_reg;
                        end
                    end else begin
                        sf_next = (dir_reg == DIR_LOW) ? sf_reg - 1'b1 : sf_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spf_reg  <= 8'd40;
            door_reg <= 9'd45;
            idle_reg <= 9'd152;
            cap_reg  <= 5'd8;
            thr_reg  <= 5'd6;
            cnt_reg  <= '0;
            ins_reg  <= '0;
            pos_reg  <= POS_W'((FLOORS - 1) * 40);
            mode_reg <= CM_IDLE;
            dir_reg  <= DIR_NONE;
            gv_reg   <= 1'b0;
            goal_reg <= '0;
            tmr_reg  <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_STEPS:    spf_reg  <= cfg_data[7:0];
                    CFG_DOOR:     door_reg <= cfg_data;
                    CFG_IDLE_RET: idle_reg <= cfg_data;
                    CFG_CAPACITY: cap_reg  <= cfg_data[4:0];
                    CFG_FULL_THR: thr_reg  <= cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
            cnt_reg  <= cnt_next;
            ins_reg  <= ins_next;
            pos_reg  <= pos_next;
            mode_reg <= mode_next;
            dir_reg  <= dir_next;
            gv_reg   <= gv_next;
            goal_reg <= goal_next;
            tmr_reg  <= tmr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            start_mem[tbl_waddr] <= tbl_wstart;
            dest_mem[tbl_waddr]  <= tbl_wdest;
            in_mem[tbl_waddr]    <= tbl_win;
        end
        bdir_reg    <= bdir_next;
        in_mode_reg <= in_mode_next;
        in_s_reg    <= in_s_next;
        in_d_reg    <= in_d_next;
        rej_reg     <= rej_next;
        icpt_reg    <= icpt_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        cf_reg      <= cf_next;
        done_reg    <= done_next;
        idx_reg     <= idx_next;
        j_reg       <= j_next;
        wl_reg      <= wl_next;
        wh_reg      <= wh_next;
        dests_reg   <= dests_next;
        lows_reg    <= lows_next;
        highs_reg   <= highs_next;
        nk_reg      <= nk_next;
        nf_reg      <= nf_next;
        best_reg    <= best_next;
        mind_reg    <= mind_next;
        found_reg   <= found_next;
        sf_reg      <= sf_next;
        pass_reg    <= pass_next;
        if (cmd.op == OP_EMIT) begin
            o_cf_reg   <= cf_reg;
            o_pos_reg  <= pos_reg;
            o_mode_reg <= mode_reg;
            o_dir_reg  <= dir_reg;
            o_gv_reg   <= gv_reg;
            o_gf_reg   <= gv_reg ? goal_reg : 2'd0;
            o_ins_reg  <= 5'(ins_reg);
            o_wait_reg <= 5'(cnt_reg - ins_reg);
            o_rej_reg  <= rej_reg;
        end
    end

    assign status.done        = done_reg;
    assign status.scan_end    = scan_end;
    assign status.is_req      = in_mode_reg;
    assign status.waiting_any = (cnt_reg > ins_reg);
    assign status.car_mode    = mode_reg;
    assign status.door_due    = (tmr_reg > door_reg);
    assign status.icpt_pend   = icpt_reg;
    assign status.masks_empty = ((dests_reg | lows_reg | highs_reg) == '0);
    assign status.dir_none    = (dir_reg == DIR_NONE);

    assign m_car_floor        = o_cf_reg;
    assign m_car_position     = o_pos_reg;
    assign m_car_mode         = o_mode_reg;
    assign m_travel_direction = o_dir_reg;
    assign m_goal_valid       = o_gv_reg;
    assign m_goal_floor       = o_gf_reg;
    assign m_riders_inside    = o_ins_reg;
    assign m_riders_waiting   = o_wait_reg;
    assign m_request_rejected = o_rej_reg;

endmodule

FILE: hw/rtl/elevator_collective_controller.sv
// Single-car elevator controller with collective scan.
// Input channel s_*: one item is a tick (s_mode 0) or a rider request
// (s_mode 1, s_start_floor, s_dest_floor). Every item yields one result
// item on m_*: car floor, position, mode, direction, goal, rider counts and
// a reject flag for dropped requests.
// Configuration: cfg_we writes cfg_data into register cfg_addr at once
// (0 steps per floor, 1 door ticks, 2 idle return ticks, 3 capacity,
// 4 full threshold); write only while no item is in flight.
// Each item first runs the floor divider (up to FLOORS steps); a tick may then
// run rider-table scans, which step one entry per cycle, and a floor search.
// A door close runs four table scans and, if calls remain, a floor search.
// One item is worked at a time; s_ready is high only between items. The
// result sits in an output register, so a stalled receiver holds the next
// result in the sequencer until m_ready frees the register.
// Reset: empty rider table, car idle at the home floor, default config.
`include "elevator_collective_controller_defines.svh"
module elevator_collective_controller
    import ecc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_mode,
    input  logic [1:0]       s_start_floor,
    input  logic [1:0]       s_dest_floor,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_car_floor,
    output logic [POS_W-1:0] m_car_position,
    output logic [1:0]       m_car_mode,
    output logic [1:0]       m_travel_direction,
    output logic             m_goal_valid,
    output logic [1:0]       m_goal_floor,
    output logic [4:0]       m_riders_inside,
    output logic [4:0]       m_riders_waiting,
    output logic             m_request_rejected,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_addr,
    input  logic [8:0]       cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ecc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ecc_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_mode             (s_mode),
        .s_start_floor      (s_start_floor),
        .s_dest_floor       (s_dest_floor),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_data           (cfg_data),
        .m_car_floor        (m_car_floor),
        .m_car_position     (m_car_position),
        .m_car_mode         (m_car_mode),
        .m_travel_direction (m_travel_direction),
        .m_goal_valid       (m_goal_valid),
        .m_goal_floor       (m_goal_floor),
        .m_riders_inside    (m_riders_inside),
        .m_riders_waiting   (m_riders_waiting),
        .m_request_rejected (m_request_rejected)
    );

    `ECC_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `ECC_ASSERT_IMP(a_riders_bounded, m_valid,
        (6'(m_riders_inside) + 6'(m_riders_waiting)) <= 6'(TABLE_SLOTS))
    `ECC_ASSERT_IMP(a_goal_zero_when_unset, m_valid && !m_goal_valid, m_goal_floor == 2'd0)

endmodule
